[src/lsm_pkg.sv]
package lsm_pkg;

    localparam int TEXT_W      = 8;
    localparam int INDEX_W     = 32;
    localparam int PAT_BYTES   = 16;
    localparam int LEN_W       = 5;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [TEXT_W-1:0] NEWLINE     = 8'd10;
    localparam logic [TEXT_W-1:0] UPPER_FIRST = 8'h41;
    localparam logic [TEXT_W-1:0] UPPER_LAST  = 8'h5A;
    localparam logic [TEXT_W-1:0] CASE_OFFSET = 8'd32;

    localparam logic [INDEX_W-1:0] INDEX_FIRST = 32'd1;
    localparam logic [INDEX_W-1:0] INDEX_MAX   = 32'hFFFF_FFFF;

    localparam logic [1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [1:0] REG_PAT_LEN  = 2'd2;
    localparam logic [1:0] REG_FOLD     = 2'd3;

    typedef struct packed {
        logic [8*PAT_BYTES-1:0] pattern;
        logic [LEN_W-1:0]       length;
        logic                   fold;
    } t_cfg;

    // Moves A-Z to lower case when folding is enabled.
    function automatic logic [TEXT_W-1:0] fold_byte(input logic [TEXT_W-1:0] c,
                                                    input logic fold);
        if (fold && c >= UPPER_FIRST && c <= UPPER_LAST) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

[src/lsm_if.sv]
interface lsm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

interface lsm_out_if;
    logic        valid;
    logic        ready;
    logic        line_hit;
    logic [31:0] line_index;
    logic        stream_done;

    modport source (output valid, output line_hit, output line_index, output stream_done,
                    input ready);
    modport sink (input valid, input line_hit, input line_index, input stream_done,
                  output ready);
endinterface

[src/lsm_regs.sv]
module lsm_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [lsm_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [lsm_pkg::DATA_W-1:0]   i_pwdata,
    output logic [lsm_pkg::DATA_W-1:0]   o_prdata,
    output logic                         o_pready,
    output lsm_pkg::t_cfg                o_cfg
);

    logic [1:0]    w_index;
    logic          w_write;
    lsm_pkg::t_cfg r_cfg;

    // Registers sit on 8-byte boundaries.
    assign w_index  = i_paddr[4:3];
    assign w_write  = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_write) begin
            unique case (w_index)
                lsm_pkg::REG_PAT_LOW:  r_cfg.pattern[63:0]   <= i_pwdata;
                lsm_pkg::REG_PAT_HIGH: r_cfg.pattern[127:64] <= i_pwdata;
                lsm_pkg::REG_PAT_LEN:  r_cfg.length <= i_pwdata[lsm_pkg::LEN_W-1:0];
                lsm_pkg::REG_FOLD:     r_cfg.fold   <= i_pwdata[0];
                default:               r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            lsm_pkg::REG_PAT_LOW:  o_prdata = r_cfg.pattern[63:0];
            lsm_pkg::REG_PAT_HIGH: o_prdata = r_cfg.pattern[127:64];
            lsm_pkg::REG_PAT_LEN:  o_prdata = 64'(r_cfg.length);
            lsm_pkg::REG_FOLD:     o_prdata = 64'(r_cfg.fold);
            default:               o_prdata = '0;
        endcase
    end

endmodule

[src/lsm_front.sv]
module lsm_front #(
    parameter int PATTERN_MAX = 16
) (
    lsm_in_if.sink                  i_text,
    input  lsm_pkg::t_cfg           i_cfg,
    input  logic                    i_q_ready,
    output logic                    o_q_valid,
    output logic [PATTERN_MAX+1:0]  o_q_data
);

    logic [lsm_pkg::TEXT_W-1:0] w_char;
    logic [PATTERN_MAX-1:0]     w_eq;
    logic                       w_eol;

    assign w_char = lsm_pkg::fold_byte(i_text.text_byte, i_cfg.fold);

    // Folding never turns another byte into a newline, so the raw byte decides.
    assign w_eol = (i_text.text_byte == lsm_pkg::NEWLINE) || i_text.final_byte;

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cmp
        if (k < lsm_pkg::PAT_BYTES) begin : g_stored
            assign w_eq[k] = lsm_pkg::fold_byte(i_cfg.pattern[8*k +: 8], i_cfg.fold)
                             == w_char;
        end else begin : g_zero
            // Positions beyond the stored bytes hold a zero byte.
            assign w_eq[k] = (w_char == '0);
        end
    end

    assign i_text.ready = i_q_ready;
    assign o_q_valid    = i_text.valid;
    assign o_q_data     = {i_text.final_byte, w_eol, w_eq};

endmodule

[src/lsm_queue.sv]
module lsm_queue #(
    parameter int WIDTH = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(lsm_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(lsm_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [lsm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != CNT_W'(lsm_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[src/lsm_back.sv]
module lsm_back #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lsm_pkg::t_cfg           i_cfg,
    input  logic                    i_q_valid,
    input  logic [PATTERN_MAX+1:0]  i_q_data,
    output logic                    o_q_pop,
    lsm_out_if.source               o_line
);

    logic [PATTERN_MAX-1:0]      r_pm;
    logic                        r_hit;
    logic [lsm_pkg::INDEX_W-1:0] r_count;
    logic                        r_out_valid;
    logic                        r_out_hit;
    logic [lsm_pkg::INDEX_W-1:0] r_out_index;
    logic                        r_out_done;

    logic [PATTERN_MAX-1:0]      w_eq;
    logic                        w_eol;
    logic                        w_last;
    logic [PATTERN_MAX-1:0]      w_pm_next;
    logic                        w_len_hit;
    logic                        w_hit_next;
    logic                        w_pop;

    assign w_eq   = i_q_data[PATTERN_MAX-1:0];
    assign w_eol  = i_q_data[PATTERN_MAX];
    assign w_last = i_q_data[PATTERN_MAX+1];

    // Ordinary bytes always drain; a line end needs the output register free.
    assign w_pop   = i_q_valid && (!w_eol || !r_out_valid || o_line.ready);
    assign o_q_pop = w_pop;

    assign w_pm_next = ((r_pm << 1) | PATTERN_MAX'(1)) & w_eq;

    always_comb begin
        int len_i;
        len_i     = int'(i_cfg.length);
        w_len_hit = 1'b0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if ((len_i == k + 1) || (len_i > PATTERN_MAX && k == PATTERN_MAX - 1)) begin
                w_len_hit = w_len_hit | w_pm_next[k];
            end
        end
    end

    assign w_hit_next = r_hit || (i_cfg.length == '0) || w_len_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm        <= '0;
            r_hit       <= 1'b0;
            r_count     <= lsm_pkg::INDEX_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop && w_eol) begin
                r_out_valid <= 1'b1;
            end else if (o_line.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_pop) begin
                if (w_eol) begin
                    r_pm        <= '0;
                    r_hit       <= 1'b0;
                    if (w_last) begin
                        r_count <= lsm_pkg::INDEX_FIRST;
                    end else if (r_count != lsm_pkg::INDEX_MAX) begin
                        r_count <= r_count + 32'd1;
                    end
                end else begin
                    r_pm  <= w_pm_next;
                    r_hit <= w_hit_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && w_eol) begin
            r_out_hit   <= w_hit_next;
            r_out_index <= r_count;
            r_out_done  <= w_last;
        end
    end

    assign o_line.valid       = r_out_valid;
    assign o_line.line_hit    = r_out_hit;
    assign o_line.line_index  = r_out_index;
    assign o_line.stream_done = r_out_done;

`ifndef SYNTHESIS
    a_clear_after_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_eol) |=> (r_pm == '0 && !r_hit))
        else $error("match state not cleared after a line end");

    a_empty_pattern_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_eol && i_cfg.length == '0) |=> (r_out_valid && r_out_hit))
        else $error("empty pattern did not report a hit");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_eol && !w_last && r_count != lsm_pkg::INDEX_MAX)
        |=> (r_count == $past(r_count) + 32'd1))
        else $error("line counter did not advance");

    a_count_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_eol && w_last) |=> (r_count == lsm_pkg::INDEX_FIRST))
        else $error("line counter did not restart after the final line");
`endif

endmodule

[src/line_substring_matcher.sv]
// Per-line substring search over a byte stream. Each input transaction carries one
// text byte and a flag that marks the last byte of the text; a line ends at a
// newline byte (which itself takes part in the compare) or at the marked byte,
// and then one output transaction reports whether the configured pattern of up to
// sixteen bytes occurred in the line, the 1-based line number (saturating at the
// 32-bit maximum) and whether this was the final line, after which numbering
// restarts at one. The block takes one byte per clock cycle unless stalled: the front
// end compares the byte against every pattern position in parallel and writes the
// result into a four-entry queue, and the back end consumes one queue entry per
// cycle with a shift-and update, but a line end waits while the output register
// holds a result that is not taken. A result passes through a queue entry and then
// the output register. Bytes stop being accepted only when such a result waits
// and the queue is full behind it. There is no clearing pass after reset. Configuration
// is through an APB port with 64-bit registers at byte addresses 0, 8, 16 and 24
// (pattern bytes 0-7, pattern bytes 8-15, pattern length, case folding) and must
// be written while the block is idle; a length above PATTERN_MAX acts as
// PATTERN_MAX, and length zero matches every line.
module line_substring_matcher #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lsm_pkg::ADDR_W-1:0]   paddr,
    input  logic [lsm_pkg::DATA_W-1:0]   pwdata,
    output logic [lsm_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    lsm_in_if.sink                       i_text,
    lsm_out_if.source                    o_line
);

    localparam int ENTRY_W = PATTERN_MAX + 2;

    lsm_pkg::t_cfg       w_cfg;
    logic                w_push;
    logic [ENTRY_W-1:0]  w_push_data;
    logic                w_q_ready;
    logic                w_q_valid;
    logic [ENTRY_W-1:0]  w_q_data;
    logic                w_pop;

    // Configuration registers and read-back.
    lsm_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    // The front end folds the byte, compares it with all pattern positions and
    // tags line ends. Each accepted transaction becomes one queue entry.
    lsm_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .i_text    (i_text),
        .i_cfg     (w_cfg),
        .i_q_ready (w_q_ready),
        .o_q_valid (w_push),
        .o_q_data  (w_push_data)
    );

    // The queue lets the input keep flowing while a result waits at the output.
    lsm_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    // The back end holds the partial match vector, the hit flag and the line
    // counter, and loads the output register at each line end.
    lsm_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_pop),
        .o_line    (o_line)
    );

endmodule

[dv/line_substring_matcher_test.sv]
`timescale 1ns / 1ps

// Self-checking bench for the per-line substring matcher.
//
// Text bytes go in through the input channel. Each accepted input transaction
// is run through a local copy of the matching rules. That copy keeps its own
// pattern, length and fold settings, its own partial-match bits, its own
// per-line hit flag and its own line counter. Whenever a byte ends a line, the
// report the block must give is queued. Every accepted output transaction is
// compared field by field against the oldest queued report.
//
// The run has two parts:
//   1. A short directed list that walks register writes and text bytes in
//      order. Rows whose outcome is obvious carry their report typed in.
//      Those typed reports replace the computed ones, so they check the block
//      independently.
//   2. Twelve random phases. Each phase rewrites all four registers while the
//      block is idle and then streams lines. Most of these lines plant the
//      pattern somewhere in filler built from the pattern's own bytes, so
//      partial and overlapping matches are common. The rest is filler or pure noise.
// Handshake pacing changes every four phases. In one phase the receiver also
// holds off for a long stretch, so the block fills up and stalls its input.
module line_substring_matcher_test;

    localparam int     RANDOM_PHASES    = 12;
    localparam int     PHASE_BYTES      = 120;
    localparam int     LONG_HOLD_PHASE  = 8;
    localparam int     LONG_HOLD_CYCLES = 80;
    localparam int     SETTLE_CYCLES    = 8;
    localparam longint CYCLE_LIMIT      = 400000;

    // Who leaves gaps in the handshake during a phase.
    typedef enum logic [1:0] {
        PACE_RECEIVER_SLOW,
        PACE_SENDER_SLOW,
        PACE_FULL_RATE
    } t_pace;

    typedef struct {
        logic                        hit;
        logic [lsm_pkg::INDEX_W-1:0] index;
        logic                        done;
    } t_line_report;

    typedef struct {
        logic [lsm_pkg::TEXT_W-1:0] text_byte;
        logic                       final_byte;
        bit                         typed;
        t_line_report               report;
    } t_text_beat;

    typedef struct {
        bit                         is_write;
        logic [1:0]                 which;
        logic [lsm_pkg::DATA_W-1:0] value;
        t_text_beat                 beat;
    } t_directed_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [lsm_pkg::ADDR_W-1:0] paddr;
    logic [lsm_pkg::DATA_W-1:0] pwdata;
    logic [lsm_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    lsm_in_if  text_if ();
    lsm_out_if line_if ();

    line_substring_matcher #(
        .PATTERN_MAX(lsm_pkg::PAT_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_text  (text_if),
        .o_line  (line_if)
    );

    // Local copy of the configuration registers. They are updated at the
    // write's access edge.
    logic [lsm_pkg::DATA_W-1:0]    pat_low  = '0;
    logic [lsm_pkg::DATA_W-1:0]    pat_high = '0;
    logic [lsm_pkg::LEN_W-1:0]     pat_len  = '0;
    logic                          pat_fold = 1'b0;

    // Local copy of the match state, as it stands after reset.
    logic [lsm_pkg::PAT_BYTES-1:0] match_bits   = '0;
    logic                          line_has_hit = 1'b0;
    logic [lsm_pkg::INDEX_W-1:0]   next_index   = lsm_pkg::INDEX_FIRST;

    t_line_report  reports_due[$];
    t_text_beat    text_queue[$];
    t_text_beat    offered;
    t_directed_row directed_rows[$];

    int unsigned bytes_pushed = 0;
    int unsigned bytes_taken  = 0;
    int          error_count  = 0;
    t_pace       pace         = PACE_RECEIVER_SLOW;
    bit          hold_armed   = 1'b0;
    bit          hold_taken   = 1'b0;
    int          hold_left    = 0;
    longint      cycle_count  = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog. No correct run comes anywhere near this many cycles.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[line_substring_matcher] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Matching rules
    // ------------------------------------------------------------------

    // The form in which a byte is compared. A-Z are lowered when folding is on.
    function automatic logic [lsm_pkg::TEXT_W-1:0] compare_form(
        input logic [lsm_pkg::TEXT_W-1:0] b);
        if (pat_fold && b >= lsm_pkg::UPPER_FIRST && b <= lsm_pkg::UPPER_LAST) begin
            return b + lsm_pkg::CASE_OFFSET;
        end
        return b;
    endfunction

    function automatic logic [lsm_pkg::TEXT_W-1:0] pattern_at(input int k);
        if (k < 8) begin
            return pat_low[8*k +: 8];
        end
        return pat_high[8*(k-8) +: 8];
    endfunction

    // Advances the shift-and state by one byte. If the byte ends a line, the
    // report for that line is queued. A typed report from the directed list
    // takes the place of the computed one.
    function automatic void scan_text_byte(input t_text_beat beat);
        logic [lsm_pkg::TEXT_W-1:0]    c;
        logic [lsm_pkg::PAT_BYTES-1:0] eq;
        t_line_report                  rep;
        int                            used;
        int                            k;
        c = compare_form(beat.text_byte);
        for (k = 0; k < lsm_pkg::PAT_BYTES; k++) begin
            eq[k] = (compare_form(pattern_at(k)) == c);
        end
        // Bit k set: pattern bytes 0..k end exactly at this byte.
        match_bits = {match_bits[lsm_pkg::PAT_BYTES-2:0], 1'b1} & eq;
        // A length beyond the pattern store acts as the full store.
        used = (int'(pat_len) > lsm_pkg::PAT_BYTES) ? lsm_pkg::PAT_BYTES : int'(pat_len);
        if (used == 0) begin
            line_has_hit = 1'b1;
        end else if (match_bits[used-1]) begin
            line_has_hit = 1'b1;
        end
        if (beat.text_byte != lsm_pkg::NEWLINE && !beat.final_byte) begin
            return;
        end
        rep.hit   = line_has_hit;
        rep.index = next_index;
        rep.done  = beat.final_byte;
        reports_due.push_back(beat.typed ? beat.report : rep);
        match_bits   = '0;
        line_has_hit = 1'b0;
        // The last line of a text restarts numbering. Otherwise the count
        // sticks at its maximum.
        if (beat.final_byte) begin
            next_index = lsm_pkg::INDEX_FIRST;
        end else if (next_index != lsm_pkg::INDEX_MAX) begin
            next_index++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_text_beat plain_beat(input logic [lsm_pkg::TEXT_W-1:0] b,
                                              input logic fin);
        t_text_beat beat;
        beat.text_byte    = b;
        beat.final_byte   = fin;
        beat.typed        = 1'b0;
        beat.report.hit   = 1'b0;
        beat.report.index = '0;
        beat.report.done  = 1'b0;
        return beat;
    endfunction

    function automatic t_directed_row text_row(input logic [lsm_pkg::TEXT_W-1:0] b,
                                               input logic fin);
        t_directed_row row;
        row.is_write = 1'b0;
        row.which    = lsm_pkg::REG_PAT_LOW;
        row.value    = '0;
        row.beat     = plain_beat(b, fin);
        return row;
    endfunction

    function automatic t_directed_row checked_row(input logic [lsm_pkg::TEXT_W-1:0] b,
                                                  input logic fin,
                                                  input logic hit, input int unsigned index,
                                                  input logic done);
        t_directed_row row;
        row                   = text_row(b, fin);
        row.beat.typed        = 1'b1;
        row.beat.report.hit   = hit;
        row.beat.report.index = index;
        row.beat.report.done  = done;
        return row;
    endfunction

    function automatic t_directed_row write_row(input logic [1:0] which,
                                                input logic [lsm_pkg::DATA_W-1:0] value);
        t_directed_row row;
        row          = text_row(8'h00, 1'b0);
        row.is_write = 1'b1;
        row.which    = which;
        row.value    = value;
        return row;
    endfunction

    function automatic void push_beat(input t_text_beat beat);
        text_queue.push_back(beat);
        bytes_pushed++;
    endfunction

    // Pattern bytes favor a few letters of both cases, so that repeats,
    // overlaps and case folding all come up, along with the byte extremes.
    function automatic logic [lsm_pkg::TEXT_W-1:0] random_pattern_byte();
        case ($urandom_range(7))
            0:       return 8'h61;
            1:       return 8'h62;
            2:       return lsm_pkg::UPPER_FIRST;
            3:       return lsm_pkg::UPPER_FIRST + 8'd1;
            4:       return 8'h00;
            5:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Filler between planted patterns. Half of these are pattern bytes, which
    // start partial matches that then break. Some are random bytes, some are
    // letters, and some sit just outside the A-Z range.
    function automatic logic [lsm_pkg::TEXT_W-1:0] filler_byte(input int used);
        int pick;
        pick = $urandom_range(9);
        if (pick < 5 && used != 0) begin
            return pattern_at($urandom_range(used - 1));
        end
        if (pick < 7) begin
            return 8'($urandom_range(255));
        end
        if (pick == 7) begin
            if ($urandom_range(1) == 1) begin
                return lsm_pkg::UPPER_FIRST + 8'($urandom_range(25));
            end
            return 8'h61 + 8'($urandom_range(25));
        end
        case ($urandom_range(3))
            0:       return lsm_pkg::UPPER_FIRST - 8'd1;
            1:       return lsm_pkg::UPPER_LAST + 8'd1;
            2:       return 8'h60;
            default: return 8'h7B;
        endcase
    endfunction

    // Queues whole lines until about 'count' bytes are waiting. One line in six
    // is pure noise; two of the other lines in three carry a planted copy of the
    // pattern. With folding on, the letters of that copy often have their case
    // flipped. With folding off, this is done less often, and such a copy is
    // expected to miss. Some lines end the text with the final flag, either on
    // a newline or on any byte.
    function automatic void queue_random_text(input int count);
        int unsigned                first;
        int                         body;
        int                         spot;
        int                         used;
        int                         k;
        int                         j;
        bit                         noise;
        logic [lsm_pkg::TEXT_W-1:0] b;
        first = bytes_pushed;
        used  = (int'(pat_len) > lsm_pkg::PAT_BYTES) ? lsm_pkg::PAT_BYTES : int'(pat_len);
        while (bytes_pushed - first < count) begin
            noise = ($urandom_range(5) == 0);
            body  = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
            spot  = ($urandom_range(2) != 0) ? $urandom_range(body) : -1;
            for (k = 0; k <= body; k++) begin
                if (k == spot && !noise) begin
                    for (j = 0; j < used; j++) begin
                        b = pattern_at(j);
                        if (((b >= lsm_pkg::UPPER_FIRST && b <= lsm_pkg::UPPER_LAST) ||
                             (b >= 8'h61 && b <= 8'h7A)) &&
                            $urandom_range(1) == 1 &&
                            (pat_fold || $urandom_range(3) == 0)) begin
                            b = b ^ lsm_pkg::CASE_OFFSET;
                        end
                        push_beat(plain_beat(b, 1'b0));
                    end
                end
                if (k < body) begin
                    b = noise ? 8'($urandom_range(255)) : filler_byte(used);
                    push_beat(plain_beat(b, 1'b0));
                end
            end
            case ($urandom_range(7))
                0:       push_beat(plain_beat(8'($urandom_range(255)), 1'b1));
                1:       push_beat(plain_beat(lsm_pkg::NEWLINE, 1'b1));
                default: push_beat(plain_beat(lsm_pkg::NEWLINE, 1'b0));
            endcase
        end
    endfunction

    function automatic bit takes_gap(input bit is_sender);
        case (pace)
            PACE_RECEIVER_SLOW: return $urandom_range(99) < (is_sender ? 21 : 55);
            PACE_SENDER_SLOW:   return $urandom_range(99) < (is_sender ? 55 : 21);
            default:            return 1'b0;
        endcase
    endfunction

    // One APB write: a setup phase, then an access phase that completes on
    // pready. The local register copy changes at that same edge.
    task automatic write_register(input logic [1:0] which,
                                  input logic [lsm_pkg::DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (which)
            lsm_pkg::REG_PAT_LOW:  pat_low  = value;
            lsm_pkg::REG_PAT_HIGH: pat_high = value;
            lsm_pkg::REG_PAT_LEN:  pat_len  = value[lsm_pkg::LEN_W-1:0];
            lsm_pkg::REG_FOLD:     pat_fold = value[0];
            default:               ;
        endcase
    endtask

    // Waits until every queued byte has been taken and every report has come
    // back. Then it leaves time for bytes that end no line to drain through
    // the block's internal queue, so that a register write cannot overtake them.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (bytes_taken != bytes_pushed || reports_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random_phase(input int phase);
        logic [lsm_pkg::DATA_W-1:0] low_bytes;
        logic [lsm_pkg::DATA_W-1:0] high_bytes;
        logic [lsm_pkg::DATA_W-1:0] word;
        logic [lsm_pkg::LEN_W-1:0]  len;
        logic                       fold;
        int                         k;
        for (k = 0; k < 8; k++) begin
            low_bytes[8*k +: 8]  = random_pattern_byte();
            high_bytes[8*k +: 8] = random_pattern_byte();
        end
        fold = ($urandom_range(1) == 1);
        // The first phases pin the extremes: an all-ones pattern at full
        // length, a pattern of NUL bytes, an empty pattern, and the largest
        // length value.
        case (phase)
            0: begin
                low_bytes  = '1;
                high_bytes = '1;
                len        = lsm_pkg::LEN_W'(lsm_pkg::PAT_BYTES);
            end
            1: begin
                low_bytes  = '0;
                high_bytes = '0;
                len        = 5'd3;
                fold       = 1'b0;
            end
            2:       len = 5'd0;
            3:       len = 5'd31;
            default: begin
                case ($urandom_range(9))
                    0:       len = 5'd0;
                    1:       len = lsm_pkg::LEN_W'(lsm_pkg::PAT_BYTES);
                    2:       len = lsm_pkg::LEN_W'($urandom_range(31,
                                                                 lsm_pkg::PAT_BYTES + 1));
                    default: len = lsm_pkg::LEN_W'($urandom_range(8, 1));
                endcase
            end
        endcase
        write_register(lsm_pkg::REG_PAT_LOW, low_bytes);
        write_register(lsm_pkg::REG_PAT_HIGH, high_bytes);
        // The unused upper bits of the narrow registers carry random junk.
        word = {$urandom, $urandom};
        word[lsm_pkg::LEN_W-1:0] = len;
        write_register(lsm_pkg::REG_PAT_LEN, word);
        word = {$urandom, $urandom};
        word[0] = fold;
        write_register(lsm_pkg::REG_FOLD, word);
        pace       = t_pace'(phase / 4);
        hold_armed = (phase == LONG_HOLD_PHASE);
        queue_random_text(PHASE_BYTES);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Input side: one transaction in flight at most. The offered byte stays
    // on the bus until it is taken, and each accepted byte is scanned by the
    // matching rules right at the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            text_if.valid <= 1'b0;
        end else begin
            if (text_if.valid && text_if.ready) begin
                scan_text_byte(offered);
                bytes_taken++;
            end
            if (!text_if.valid || text_if.ready) begin
                if (text_queue.size() != 0 && !takes_gap(1'b1)) begin
                    offered = text_queue.pop_front();
                    text_if.valid      <= 1'b1;
                    text_if.text_byte  <= offered.text_byte;
                    text_if.final_byte <= offered.final_byte;
                end else begin
                    text_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: checks each accepted report against the oldest one due
    // and drives ready. Once armed, the long hold keeps ready low. The sender
    // keeps offering bytes during the hold, so the block's queue fills up and
    // it must stall its input.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_line_report want;
        if (line_if.valid && line_if.ready) begin
            if (reports_due.size() == 0) begin
                $display("%0t: line report with none due: hit %0d index %0d done %0d",
                         $time, line_if.line_hit, line_if.line_index, line_if.stream_done);
                error_count++;
            end else begin
                want = reports_due.pop_front();
                if (line_if.line_hit !== want.hit) begin
                    $display("%0t: line_hit expected %0d actual %0d",
                             $time, want.hit, line_if.line_hit);
                    error_count++;
                end
                if (line_if.line_index !== want.index) begin
                    $display("%0t: line_index expected %0d actual %0d",
                             $time, want.index, line_if.line_index);
                    error_count++;
                end
                if (line_if.stream_done !== want.done) begin
                    $display("%0t: stream_done expected %0d actual %0d",
                             $time, want.done, line_if.stream_done);
                    error_count++;
                end
            end
        end
        if (!i_rst_n) begin
            line_if.ready <= 1'b0;
        end else if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD_CYCLES;
            line_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            line_if.ready <= 1'b0;
        end else begin
            line_if.ready <= !takes_gap(1'b0);
        end
    end

    // ------------------------------------------------------------------
    // Sequencing: reset, directed list, random phases, drain, verdict.
    // ------------------------------------------------------------------
    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;

        // The directed list starts from reset, where the pattern is empty and
        // every line counts as a hit. It then covers a simple two-byte
        // pattern with folding off and on, a newline as a pattern byte, the
        // edges of the A-Z range under folding, and an oversize length.
        directed_rows = '{
            text_row(8'h00, 1'b0),                       // a NUL is an ordinary byte
            checked_row(lsm_pkg::NEWLINE, 1'b0, 1'b1, 1, 1'b0),
            checked_row(8'hFF, 1'b1, 1'b1, 2, 1'b1),     // final byte ends the text
            write_row(lsm_pkg::REG_PAT_LOW, 64'h4261),   // "aB"
            write_row(lsm_pkg::REG_PAT_LEN, 64'd2),
            text_row(8'h61, 1'b0),
            text_row(8'h42, 1'b0),
            checked_row(lsm_pkg::NEWLINE, 1'b0, 1'b1, 1, 1'b0),
            text_row(8'h41, 1'b0),                       // "Ab" misses without folding
            text_row(8'h62, 1'b0),
            checked_row(lsm_pkg::NEWLINE, 1'b0, 1'b0, 2, 1'b0),
            write_row(lsm_pkg::REG_FOLD, 64'd1),
            text_row(8'h41, 1'b0),                       // ... and hits with it
            text_row(8'h62, 1'b0),
            checked_row(8'h78, 1'b1, 1'b1, 3, 1'b1),
            write_row(lsm_pkg::REG_PAT_LOW, 64'h0A),     // pattern is a lone newline
            write_row(lsm_pkg::REG_PAT_LEN, 64'd1),
            write_row(lsm_pkg::REG_FOLD, 64'd0),
            text_row(8'h71, 1'b0),
            checked_row(lsm_pkg::NEWLINE, 1'b0, 1'b1, 1, 1'b0),
            checked_row(lsm_pkg::UPPER_FIRST, 1'b1, 1'b0, 2, 1'b1),
            write_row(lsm_pkg::REG_PAT_LOW, 64'h5B7A),   // "z[" with folding
            write_row(lsm_pkg::REG_PAT_LEN, 64'd2),
            write_row(lsm_pkg::REG_FOLD, 64'd1),
            text_row(lsm_pkg::UPPER_LAST, 1'b0),
            text_row(lsm_pkg::UPPER_LAST + 8'd1, 1'b0),
            text_row(lsm_pkg::NEWLINE, 1'b0),
            write_row(lsm_pkg::REG_PAT_LOW, 64'h405A),   // "Z@": the pattern side folds too
            text_row(8'h7A, 1'b0),
            text_row(lsm_pkg::UPPER_FIRST - 8'd1, 1'b0),
            text_row(lsm_pkg::NEWLINE, 1'b1),            // newline that also ends the text
            write_row(lsm_pkg::REG_PAT_LOW, '1),
            write_row(lsm_pkg::REG_PAT_HIGH, '1),
            write_row(lsm_pkg::REG_PAT_LEN, 64'd31),     // acts as sixteen bytes
            checked_row(8'hFF, 1'b1, 1'b0, 1, 1'b1)
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_write) begin
                wait_idle();
                write_register(directed_rows[r].which, directed_rows[r].value);
            end else begin
                push_beat(directed_rows[r].beat);
            end
        end
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            run_random_phase(phase);
        end

        // The last phase has already drained. A short extra wait catches any
        // report that comes with none due.
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[line_substring_matcher] OK");
        end else begin
            $display("[line_substring_matcher] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
src/lsm_pkg.sv
src/lsm_if.sv
src/lsm_regs.sv
src/lsm_front.sv
src/lsm_queue.sv
src/lsm_back.sv
src/line_substring_matcher.sv
dv/line_substring_matcher_test.sv
